[src/base64_stream_encoder_core_assert.svh]
// Assertion macros for the base64 stream encoder.
// Included by the top level; expects clk and rst_n in scope.
`ifndef BASE64_STREAM_ENCODER_CORE_ASSERT_SVH
`define BASE64_STREAM_ENCODER_CORE_ASSERT_SVH

// same-cycle implication
`define B64SE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define B64SE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/b64se_pkg.sv]
// Shared types, constants and the symbol lookup for the base64 stream encoder.
// No dependencies.
package b64se_pkg;

  localparam int BYTE_W      = 8;
  localparam int CHAR_W      = 7;
  localparam int SEXTET_W    = 6;
  localparam int GROUP_W     = 24;
  localparam int PAD_W       = 2;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CHAR_W-1:0] PAD_CHAR = 7'h3D;

  typedef struct packed {
    logic [GROUP_W-1:0] word;
    logic [PAD_W-1:0]   pads;
    logic               fin;
  } grp_t;

  function automatic logic [CHAR_W-1:0] sym_char(input logic [SEXTET_W-1:0] s);
    logic [7:0] c;
    if (s < 6'd26) begin
      c = 8'd65 + {2'b00, s};
    end else if (s < 6'd52) begin
      c = 8'd71 + {2'b00, s};
    end else if (s < 6'd62) begin
      c = {2'b00, s} - 8'd4;
    end else if (s == 6'd62) begin
      c = 8'd43;
    end else begin
      c = 8'd47;
    end
    return c[CHAR_W-1:0];
  endfunction

endpackage

[src/b64se_if.sv]
// Handshake channel interfaces for the byte input and the character output.
// Depends on b64se_pkg.
interface b64se_byte_if;
  logic                         valid;
  logic                         ready;
  logic [b64se_pkg::BYTE_W-1:0] data_byte;
  logic                         end_of_stream;
  modport source (output valid, data_byte, end_of_stream, input ready);
  modport sink (input valid, data_byte, end_of_stream, output ready);
endinterface

interface b64se_char_if;
  logic                         valid;
  logic                         ready;
  logic [b64se_pkg::CHAR_W-1:0] code_char;
  logic                         final_char;
  modport source (output valid, code_char, final_char, input ready);
  modport sink (input valid, code_char, final_char, output ready);
endinterface

[src/base64_stream_encoder_core.sv]
// Top level of the base64 stream encoder: front end, group queue, back end.
// Depends on b64se_pkg, b64se_if, b64se_front, b64se_queue, b64se_back.
//
// Usage:
//   in_ch  : one request per raw byte, with end_of_stream on the last byte.
//   out_ch : one request per base64 ASCII character; final_char marks the
//            last character of an encoded stream ('=' padding included).
//   Every third byte, or any byte flagged end_of_stream, completes a group
//   that becomes exactly four characters.
// Path: when the back end is idle, the group a byte completes goes through the
//   queue and the back end's group register into the output register.
// Throughput: the back end sends one character per cycle while out_ch is ready
//   and it holds a group, four characters per three input bytes; the front end
//   takes one byte per cycle while the group queue has room.
// Stalls: when out_ch is not ready the current character holds in the
//   output register, the back end waits, and once the queue of
//   QueueDepth groups is full in_ch.ready drops.
// Reset: synchronous, active low; clears the held bytes, the queue and the
//   output valid. No setup pass is needed after reset.
module base64_stream_encoder_core #(
  parameter int QueueDepth = b64se_pkg::QUEUE_DEPTH
) (
  input logic          clk,
  input logic          rst_n,
  b64se_byte_if.sink   in_ch,
  b64se_char_if.source out_ch
);
  import b64se_pkg::*;

  `include "base64_stream_encoder_core_assert.svh"

  grp_t push_data, q_data;
  logic q_push, q_pop, q_valid, q_full;

  b64se_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .in_data_byte     (in_ch.data_byte),
    .in_end_of_stream (in_ch.end_of_stream),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_data           (push_data)
  );

  b64se_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .full      (q_full)
  );

  b64se_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_data         (q_data),
    .q_pop          (q_pop),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_code_char  (out_ch.code_char),
    .out_final_char (out_ch.final_char)
  );

  `B64SE_ASSERT_NOW(a_no_overflow, q_push, !q_full, "group pushed into full queue")
  `B64SE_ASSERT_NOW(a_no_underflow, q_pop, q_valid, "group popped from empty queue")
  `B64SE_ASSERT_NOW(a_eos_flushes, in_ch.valid && in_ch.ready && in_ch.end_of_stream, q_push, "end of stream did not flush group")

endmodule

[src/b64se_front.sv]
// Front end: gathers bytes into groups of up to three and pushes each
// group (word, pad count, final flag) to the queue. Depends on b64se_pkg.
module b64se_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [b64se_pkg::BYTE_W-1:0] in_data_byte,
  input  logic                         in_end_of_stream,
  input  logic                         q_full,
  output logic                         q_push,
  output b64se_pkg::grp_t              q_data
);
  import b64se_pkg::*;

  logic [2*BYTE_W-1:0] pend_r, pend_nxt;
  logic [1:0]          cnt_r, cnt_nxt;
  logic                accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept && (in_end_of_stream || cnt_r[1]);

  always_comb begin
    case (cnt_r)
      2'd0: begin
        q_data.word = {in_data_byte, {(2*BYTE_W){1'b0}}};
        q_data.pads = PAD_W'(2);
        q_data.fin  = 1'b1;
      end
      2'd1: begin
        q_data.word = {pend_r[2*BYTE_W-1:BYTE_W], in_data_byte, {BYTE_W{1'b0}}};
        q_data.pads = PAD_W'(1);
        q_data.fin  = 1'b1;
      end
      default: begin
        q_data.word = {pend_r, in_data_byte};
        q_data.pads = '0;
        q_data.fin  = in_end_of_stream;
      end
    endcase
  end

  always_comb begin
    pend_nxt = pend_r;
    cnt_nxt  = cnt_r;
    if (q_push) begin
      pend_nxt = '0;
      cnt_nxt  = '0;
    end else if (accept) begin
      if (cnt_r == 2'd0) begin
        pend_nxt = {in_data_byte, {BYTE_W{1'b0}}};
        cnt_nxt  = 2'd1;
      end else begin
        pend_nxt = {pend_r[2*BYTE_W-1:BYTE_W], in_data_byte};
        cnt_nxt  = 2'd2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      cnt_r  <= '0;
    end else begin
      pend_r <= pend_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

[src/b64se_queue.sv]
// Small FIFO of completed groups between front and back ends.
// Depends on b64se_pkg. Depth of 2 or more.
module b64se_queue #(
  parameter int Depth = b64se_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  b64se_pkg::grp_t push_data,
  input  logic            pop,
  output logic            q_valid,
  output b64se_pkg::grp_t q_data,
  output logic            full
);
  import b64se_pkg::*;

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  grp_t            mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] cnt_r;
  logic            do_push, do_pop;

  assign full    = (cnt_r == CntW'(Depth));
  assign q_valid = (cnt_r != '0);
  assign q_data  = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

[src/b64se_back.sv]
// Back end: takes one group at a time from the queue and sends its four characters,
// one per cycle unless out_ready stalls, via an output register. Depends on b64se_pkg.
module b64se_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  b64se_pkg::grp_t              q_data,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [b64se_pkg::CHAR_W-1:0] out_code_char,
  output logic                         out_final_char
);
  import b64se_pkg::*;

  grp_t                cur_r, cur_nxt;
  logic                cur_valid_r, cur_valid_nxt;
  logic [1:0]          idx_r, idx_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]   char_r, char_nxt;
  logic                fin_r, fin_nxt;
  logic                advance;
  logic [SEXTET_W-1:0] sextet;
  logic                is_pad;

  assign advance = cur_valid_r && (!out_valid_r || out_ready);

  always_comb begin
    case (idx_r)
      2'd0:    sextet = cur_r.word[23:18];
      2'd1:    sextet = cur_r.word[17:12];
      2'd2:    sextet = cur_r.word[11:6];
      default: sextet = cur_r.word[5:0];
    endcase
    is_pad = ((idx_r == 2'd3) && (cur_r.pads != '0)) ||
             ((idx_r == 2'd2) && (cur_r.pads == PAD_W'(2)));
  end

  always_comb begin
    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    char_nxt      = char_r;
    fin_nxt       = fin_r;
    q_pop         = 1'b0;
    if (advance) begin
      out_valid_nxt = 1'b1;
      char_nxt      = is_pad ? PAD_CHAR : sym_char(sextet);
      fin_nxt       = cur_r.fin && (idx_r == 2'd3);
      idx_nxt       = idx_r + 2'd1;
      if (idx_r == 2'd3) begin
        cur_valid_nxt = q_valid;
        cur_nxt       = q_data;
        q_pop         = q_valid;
      end
    end else if (!cur_valid_r) begin
      cur_valid_nxt = q_valid;
      cur_nxt       = q_data;
      q_pop         = q_valid;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    char_r <= char_nxt;
    fin_r  <= fin_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_code_char  = char_r;
  assign out_final_char = fin_r;

endmodule

[bench/tb_base64_stream_encoder_core.sv]
`timescale 1ns / 1ps
// Self-checking bench for base64_stream_encoder_core: byte requests in, ASCII chars out.
// Depends on b64se_pkg, b64se_if and the core; expected chars come from a local encoder or the directed table.
module tb_base64_stream_encoder_core;
  import b64se_pkg::*;

  localparam string B64_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  localparam int RANDOM_BYTES = 100;
  localparam int HOLD_AT_CHAR = 30;
  localparam int HOLD_CYCLES  = 100;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              fin;
  } b64_char_t;

  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              eos;
    string             want;
  } byte_row_t;

  logic clk = 1'b0;
  logic rst_n;

  b64se_byte_if in_ch();
  b64se_char_if out_ch();

  base64_stream_encoder_core dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  always #5 clk = ~clk;

  logic [15:0] held_word;
  logic [1:0]  held_count;
  b64_char_t   awaited_chars[$];
  int          mismatch_count = 0;
  int          taken_chars = 0;
  bit          sender_burst = 1'b0;

  byte_row_t directed_rows[21] = '{
    '{8'h4D, 1'b0, ""}, '{8'h61, 1'b0, ""}, '{8'h6E, 1'b0, "TWFu"},
    '{8'h4D, 1'b1, "TQ=="},
    '{8'h4D, 1'b0, ""}, '{8'h61, 1'b1, "TWE="},
    '{8'hFF, 1'b0, ""}, '{8'hFF, 1'b0, ""}, '{8'hFF, 1'b1, "////"},
    '{8'h00, 1'b0, ""}, '{8'h00, 1'b0, ""}, '{8'h00, 1'b0, "AAAA"},
    '{8'h00, 1'b1, "AA=="},
    '{8'hFF, 1'b1, "/w=="},
    '{8'hFB, 1'b0, ""}, '{8'hEF, 1'b1, "++8="},
    '{8'hFF, 1'b0, ""}, '{8'hFF, 1'b1, "//8="},
    '{8'h00, 1'b0, ""}, '{8'h10, 1'b0, ""}, '{8'h83, 1'b0, "ABCD"}
  };

  function automatic logic [CHAR_W-1:0] b64_letter(input logic [23:0] word, input int shift);
    logic [5:0] idx;
    idx = word[shift +: 6];
    return CHAR_W'(B64_ALPHABET[idx]);
  endfunction

  // advance the encoder state by one byte; returns the number of chars produced
  function automatic int encode_byte(input logic [BYTE_W-1:0] data, input logic eos,
                                     output b64_char_t chars[4]);
    logic [23:0] word;
    int          n;
    n = 0;
    for (int k = 0; k < 4; k++) chars[k] = '0;
    case (held_count)
      2'd0: begin
        if (!eos) begin
          held_word  = {data, 8'h00};
          held_count = 2'd1;
        end else begin
          word     = {data, 16'h0000};
          chars[0] = '{b64_letter(word, 18), 1'b0};
          chars[1] = '{b64_letter(word, 12), 1'b0};
          chars[2] = '{PAD_CHAR, 1'b0};
          chars[3] = '{PAD_CHAR, 1'b1};
          n = 4;
        end
      end
      2'd1: begin
        if (!eos) begin
          held_word  = {held_word[15:8], data};
          held_count = 2'd2;
        end else begin
          word     = {held_word[15:8], data, 8'h00};
          chars[0] = '{b64_letter(word, 18), 1'b0};
          chars[1] = '{b64_letter(word, 12), 1'b0};
          chars[2] = '{b64_letter(word, 6), 1'b0};
          chars[3] = '{PAD_CHAR, 1'b1};
          n = 4;
        end
      end
      default: begin
        word     = {held_word, data};
        chars[0] = '{b64_letter(word, 18), 1'b0};
        chars[1] = '{b64_letter(word, 12), 1'b0};
        chars[2] = '{b64_letter(word, 6), 1'b0};
        chars[3] = '{b64_letter(word, 0), eos};
        n = 4;
      end
    endcase
    if (n != 0) begin
      held_word  = '0;
      held_count = '0;
    end
    return n;
  endfunction

  function automatic void add_awaited(input b64_char_t c);
    awaited_chars.insert(awaited_chars.size(), c);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] data, input logic eos, input string want);
    b64_char_t chars[4];
    int        gap;
    int        n;
    gap = sender_burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.data_byte     <= data;
    in_ch.end_of_stream <= eos;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    n = encode_byte(data, eos, chars);
    if (want.len() == 4 && n == 4) begin
      for (int k = 0; k < 4; k++) chars[k].code = CHAR_W'(want[k]);
    end
    for (int k = 0; k < n; k++) add_awaited(chars[k]);
  endtask

  // char checker
  always @(posedge clk) begin
    b64_char_t exp_char;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (awaited_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected char 0x%02h final=%0b",
                                  out_ch.code_char, out_ch.final_char));
      end else begin
        exp_char = awaited_chars.pop_front();
        if (out_ch.code_char !== exp_char.code)
          report_mismatch($sformatf("code_char 0x%02h, expected 0x%02h",
                                    out_ch.code_char, exp_char.code));
        if (out_ch.final_char !== exp_char.fin)
          report_mismatch($sformatf("final_char %0b, expected %0b",
                                    out_ch.final_char, exp_char.fin));
      end
    end
  end

  // receiver: random stalls, bursts with none, and one long hold-off
  initial begin
    int hold;
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (taken_chars == HOLD_AT_CHAR) begin
        hold = HOLD_CYCLES;
      end else if ((taken_chars % 64) < 16) begin
        hold = 0;
      end else begin
        hold = $urandom_range(0, 9);
      end
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      taken_chars++;
    end
  end

  initial begin
    #2_000_000;
    $display("base64_stream_encoder_core regression: fail");
    $finish;
  end

  initial begin
    int sent;
    int len;
    held_word           = '0;
    held_count          = '0;
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.data_byte     = '0;
    in_ch.end_of_stream = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_byte(directed_rows[i].data, directed_rows[i].eos, directed_rows[i].want);

    sent = 0;
    while (sent < RANDOM_BYTES) begin
      if ($urandom_range(0, 3) == 0) sender_burst = ~sender_burst;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) : $urandom_range(1, 6);
      for (int i = 0; i < len; i++) begin
        send_byte(BYTE_W'($urandom_range(0, 255)), i == len - 1, "");
      end
      sent += len;
    end
    in_ch.valid <= 1'b0;

    while (awaited_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("base64_stream_encoder_core regression: pass");
    end else begin
      $display("base64_stream_encoder_core regression: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/b64se_pkg.sv
src/b64se_if.sv
src/b64se_front.sv
src/b64se_queue.sv
src/b64se_back.sv
src/base64_stream_encoder_core.sv
bench/tb_base64_stream_encoder_core.sv
